// ===== hw/rtl/vhmt_pkg.sv =====
`default_nettype none

package vhmt_pkg;

    localparam int unsigned NUM_FECS_DEFAULT = 16;
    localparam int unsigned NUM_CHIPS        = 32;
    localparam int unsigned SID_BASE         = 10;
    localparam int unsigned TS_W             = 42;
    localparam int unsigned OUT_TS_W         = 43;
    localparam int unsigned HM_W             = 20;
    localparam int unsigned RAW_IDX_W        = 10;
    localparam int unsigned CFG_ADDR_W       = 3;

    localparam logic [4:0]  SID_FIRST          = 5'd11;
    localparam logic [10:0] TRIG_ENTRY_OFFSET  = 11'd16;
    localparam logic [4:0]  CHIP_SPLIT         = 5'd15;
    localparam logic [1:0]  TRIG_MODE_EXTERNAL = 2'd1;
    localparam logic        REG_TRIGGER_MODE   = 1'b0;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    typedef logic [1:0] op_t;
    localparam op_t OP_PASS   = 2'd0;
    localparam op_t OP_HIT    = 2'd1;
    localparam op_t OP_MARKER = 2'd2;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_MARKER = 3'd0;
    localparam kind_t KIND_TRIG   = 3'd1;
    localparam kind_t KIND_HIT    = 3'd2;
    localparam kind_t KIND_PASS   = 3'd3;
    localparam kind_t KIND_ERR    = 3'd4;

    typedef struct packed {
        op_t                  op;
        logic [4:0]           chip;
        logic [5:0]           chan;
        logic [RAW_IDX_W-1:0] idx;
        logic [4:0]           toff;
        logic [11:0]          bcid;
        logic [TS_W-1:0]      ts;
        logic                 is_end;
        logic                 ts_zero;
        logic                 hm_zero;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        kind_t               kind;
        logic [OUT_TS_W-1:0] ts;
        logic [HM_W-1:0]     hm;
        logic [4:0]          chip;
        logic [5:0]          chan;
        logic [31:0]         early;
        logic [31:0]         err;
    } result_t;

    function automatic logic [11:0] gray_decode12(input logic [11:0] g);
        logic [11:0] b;
        b = g;
        b = b ^ (b >> 1);
        b = b ^ (b >> 2);
        b = b ^ (b >> 4);
        b = b ^ (b >> 8);
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vhmt_ram.sv =====
`default_nettype none

module vhmt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vhmt_queue.sv =====
`default_nettype none

module vhmt_queue
    import vhmt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      head,
    output q_status_t  status
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/vhmt_front.sv =====
`default_nettype none

module vhmt_front
    import vhmt_pkg::*;
#(
    parameter int unsigned NUM_FECS = NUM_FECS_DEFAULT
) (
    input  wire logic        start,
    input  wire logic [4:0]  source_id,
    input  wire logic [31:0] data_word_a,
    input  wire logic [15:0] data_word_b,
    input  wire q_status_t   q_status,
    input  wire logic        clearing,
    output logic             busy,
    output logic             push,
    output item_t            item
);

    localparam int unsigned SID_LAST = SID_BASE + NUM_FECS;

    logic       is_hit;
    logic       in_range;
    logic [4:0] chip;
    logic [4:0] fec;

    always_comb
    begin
        is_hit   = data_word_b[15];
        chip     = is_hit ? data_word_a[26:22] : data_word_b[14:10];
        in_range = (source_id >= SID_FIRST) && ({2'b00, source_id} <= 7'(SID_LAST));
        fec      = source_id - SID_FIRST;

        if (!in_range)
        begin
            item.op = OP_PASS;
        end
        else if (is_hit)
        begin
            item.op = OP_HIT;
        end
        else
        begin
            item.op = OP_MARKER;
        end
        item.chip    = chip;
        item.chan    = is_hit ? data_word_b[13:8] : 6'd0;
        item.idx     = {fec, chip};
        item.toff    = data_word_a[31:27];
        item.bcid    = gray_decode12(data_word_a[11:0]);
        item.ts      = {data_word_a, data_word_b[9:0]};
        item.is_end  = &item.ts;
        item.ts_zero = (item.ts == '0);
        item.hm_zero = (item.ts[HM_W-1:0] == '0);
    end

    assign busy = q_status.full || clearing;
    assign push = start && !busy;

endmodule

`default_nettype wire

// ===== hw/rtl/vhmt_back.sv =====
`default_nettype none

module vhmt_back
    import vhmt_pkg::*;
#(
    parameter int unsigned NUM_FECS = NUM_FECS_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      ext,
    input  wire q_status_t q_status,
    input  wire item_t     head,
    output logic           pop,
    output logic           clearing,
    output logic           res_valid,
    output result_t        res
);

    localparam int unsigned TABLE_SIZE = NUM_FECS * NUM_CHIPS;
    localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
    localparam int unsigned A_W        = TS_W + 1;
    localparam int unsigned B_W        = HM_W + 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             run_ended_reg, run_ended_next;
    logic             epoch_reg, epoch_next;
    logic [31:0]      early_reg, early_next;
    logic [31:0]      err_reg, err_next;
    logic             done_reg, done_next;
    item_t            cur_reg;
    logic             oob_reg;
    result_t          res_reg, res_next;

    logic [10:0]      head_tidx;
    logic             head_oob;
    logic             use_trig;
    logic [IDX_W-1:0] a_raddr, b_raddr;
    logic [IDX_W-1:0] a_waddr, b_waddr;
    logic [A_W-1:0]   a_wdata, a_rdata;
    logic [B_W-1:0]   b_wdata, b_rdata;
    logic             a_we, b_we;

    logic [TS_W-1:0]     a_time;
    logic                a_started;
    logic [HM_W-1:0]     hm_val;
    logic [TS_W-1:0]     trig_time;
    logic [OUT_TS_W-1:0] hit_sum;
    logic                chip_le;
    logic                chip_lt;

    vhmt_ram #(
        .WIDTH (A_W),
        .DEPTH (TABLE_SIZE)
    ) u_time_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    vhmt_ram #(
        .WIDTH (B_W),
        .DEPTH (TABLE_SIZE)
    ) u_hm_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    always_comb
    begin
        head_tidx = {1'b0, head.idx} + TRIG_ENTRY_OFFSET;
        head_oob  = ({1'b0, head_tidx} >= 12'(TABLE_SIZE));
        use_trig  = (head.op == OP_HIT) && ext;
        a_raddr   = (use_trig && !head_oob) ? IDX_W'(head_tidx) : IDX_W'(head.idx);
        b_raddr   = IDX_W'(head.idx);
    end

    always_comb
    begin
        a_started = a_rdata[TS_W];
        a_time    = a_rdata[TS_W-1:0];
        hm_val    = (b_rdata[HM_W] == epoch_reg) ? b_rdata[HM_W-1:0] : '0;
        trig_time = oob_reg ? '0 : a_time;
        hit_sum   = {1'b0, a_time} + {26'd0, cur_reg.toff, cur_reg.bcid};
        chip_le   = (cur_reg.chip <= CHIP_SPLIT);
        chip_lt   = (cur_reg.chip < CHIP_SPLIT);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        run_ended_next = run_ended_reg;
        epoch_next     = epoch_reg;
        early_next     = early_reg;
        err_next       = err_reg;
        done_next      = 1'b0;
        pop            = 1'b0;
        a_we           = 1'b0;
        b_we           = 1'b0;
        a_waddr        = IDX_W'(cur_reg.idx);
        b_waddr        = IDX_W'(cur_reg.idx);
        a_wdata        = {1'b1, cur_reg.ts};
        b_wdata        = {epoch_reg, cur_reg.ts[HM_W-1:0]};
        res_next       = res_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                a_we    = 1'b1;
                b_we    = 1'b1;
                a_waddr = clr_cnt_reg;
                b_waddr = clr_cnt_reg;
                a_wdata = '0;
                b_wdata = '0;
                if (clr_cnt_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                done_next     = 1'b1;
                state_next    = ST_IDLE;
                res_next.kind = KIND_MARKER;
                res_next.ts   = '0;
                res_next.hm   = '0;
                res_next.chip = cur_reg.chip;
                res_next.chan = '0;
                unique case (cur_reg.op)
                    OP_HIT:
                    begin
                        res_next.kind = KIND_HIT;
                        res_next.chan = cur_reg.chan;
                        if (ext)
                        begin
                            res_next.ts = {1'b0, trig_time};
                            res_next.hm = hm_val;
                            if (trig_time == '0)
                            begin
                                early_next = early_reg + 1'b1;
                            end
                        end
                        else if (a_time == '0)
                        begin
                            early_next = early_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.ts = hit_sum;
                        end
                    end
                    OP_MARKER:
                    begin
                        if (ext && cur_reg.is_end)
                        begin
                            if (!run_ended_reg)
                            begin
                                epoch_next = !epoch_reg;
                            end
                            run_ended_next = 1'b1;
                            res_next.kind  = KIND_PASS;
                        end
                        else if (a_started)
                        begin
                            if (ext)
                            begin
                                if (!cur_reg.hm_zero && chip_le)
                                begin
                                    b_we = 1'b1;
                                end
                                else if (!cur_reg.ts_zero && !chip_le)
                                begin
                                    a_we          = 1'b1;
                                    res_next.ts   = {1'b0, cur_reg.ts};
                                    res_next.kind = KIND_TRIG;
                                end
                                else if (!chip_le)
                                begin
                                    err_next      = err_reg + 1'b1;
                                    res_next.kind = KIND_ERR;
                                end
                            end
                            else if (chip_lt)
                            begin
                                if (!cur_reg.ts_zero)
                                begin
                                    a_we        = 1'b1;
                                    res_next.ts = {1'b0, cur_reg.ts};
                                end
                                else
                                begin
                                    err_next      = err_reg + 1'b1;
                                    res_next.kind = KIND_ERR;
                                end
                            end
                        end
                        else
                        begin
                            a_we           = 1'b1;
                            a_wdata        = {1'b1, {TS_W{1'b0}}};
                            run_ended_next = 1'b1;
                            res_next.kind  = KIND_PASS;
                        end
                    end
                    default:
                    begin
                        res_next.kind = KIND_PASS;
                    end
                endcase
                res_next.early = early_next;
                res_next.err   = err_next;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            run_ended_reg <= 1'b0;
            epoch_reg     <= 1'b0;
            early_reg     <= '0;
            err_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            run_ended_reg <= run_ended_next;
            epoch_reg     <= epoch_next;
            early_reg     <= early_next;
            err_reg       <= err_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
            oob_reg <= use_trig && head_oob;
        end
        res_reg <= res_next;
    end

    assign clearing  = (state_reg == ST_CLEAR);
    assign res_valid = done_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vmm_hit_marker_timestamper_core.sv =====
`default_nettype none

// Readout word timestamper. A word is taken at a clock edge with start high and busy low;
// its result comes out on done for exactly one cycle, after the queue slot, the registered
// table read and the result register, and cannot be held off. A two-beat queue sits in
// front of the table unit, which takes one word at a time through a table read state and
// an update and result state before it pops the next; busy rises while the queue is full.
// After reset busy also stays high while all NUM_FECS*32 table entries are cleared;
// trigger_mode may be written during that time.
module vmm_hit_marker_timestamper_core
    import vhmt_pkg::*;
#(
    parameter int unsigned NUM_FECS = NUM_FECS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [4:0]            source_id,
    input  wire logic [31:0]           data_word_a,
    input  wire logic [15:0]           data_word_b,
    output logic                       done,
    output logic      [2:0]            kind,
    output logic      [OUT_TS_W-1:0]   timestamp,
    output logic      [HM_W-1:0]       hit_marker,
    output logic      [4:0]            chip_id,
    output logic      [5:0]            channel,
    output logic      [31:0]           early_data_count,
    output logic      [31:0]           marker_error_count
);

    logic [1:0] trigger_mode_reg;
    logic       cfg_hit;
    logic       ext;
    logic       push;
    logic       pop;
    logic       clearing;
    item_t      push_item;
    item_t      head;
    q_status_t  q_status;
    result_t    res;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[CFG_ADDR_W-1] == REG_TRIGGER_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_mode_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            trigger_mode_reg <= pwdata[1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            prdata = {30'd0, trigger_mode_reg};
        end
    end

    assign ext = (trigger_mode_reg == TRIG_MODE_EXTERNAL);

    vhmt_front #(
        .NUM_FECS (NUM_FECS)
    ) u_front (
        .start       (start),
        .source_id   (source_id),
        .data_word_a (data_word_a),
        .data_word_b (data_word_b),
        .q_status    (q_status),
        .clearing    (clearing),
        .busy        (busy),
        .push        (push),
        .item        (push_item)
    );

    vhmt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    vhmt_back #(
        .NUM_FECS (NUM_FECS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ext       (ext),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .clearing  (clearing),
        .res_valid (done),
        .res       (res)
    );

    assign kind               = res.kind;
    assign timestamp          = res.ts;
    assign hit_marker         = res.hm;
    assign chip_id            = res.chip;
    assign channel            = res.chan;
    assign early_data_count   = res.early;
    assign marker_error_count = res.err;

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_accept_queued : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !q_status.empty)
        else $error("accepted beat not held in queue");

    a_no_result_clear : assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !done)
        else $error("result issued during table clear");

    a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== tb/timestamp_checker.sv =====
`timescale 1ns / 100ps

module timestamp_checker
    import vhmt_pkg::*;
#(
    parameter int unsigned NUM_FECS = NUM_FECS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic [4:0]            source_id,
    input  wire logic [31:0]           data_word_a,
    input  wire logic [15:0]           data_word_b,
    input  wire logic                  done,
    input  wire logic [2:0]            kind,
    input  wire logic [OUT_TS_W-1:0]   timestamp,
    input  wire logic [HM_W-1:0]       hit_marker,
    input  wire logic [4:0]            chip_id,
    input  wire logic [5:0]            channel,
    input  wire logic [31:0]           early_data_count,
    input  wire logic [31:0]           marker_error_count,
    output int                         fail_count,
    output int                         pending,
    output int                         checked
);

    localparam int TABLE_DEPTH = NUM_FECS * NUM_CHIPS;
    localparam logic [CFG_ADDR_W-1:0] TRIGGER_MODE_ADDR = {REG_TRIGGER_MODE, 2'b00};

    logic [TS_W-1:0] marker_time [TABLE_DEPTH];
    logic [HM_W-1:0] marker_hm [TABLE_DEPTH];
    logic            entry_started [TABLE_DEPTH];
    logic            run_over;
    logic [31:0]     early_hits;
    logic [31:0]     bad_markers;
    logic [1:0]      trig_mode;

    result_t expected_stamps [$];
    int fails = 0;
    int queued = 0;
    int compared = 0;

    assign fail_count = fails;
    assign pending = queued;
    assign checked = compared;

    function automatic logic [11:0] bunch_from_gray(input logic [11:0] g);
        logic [11:0] bin;
        bin[11] = g[11];
        for (int i = 10; i >= 0; i--)
            bin[i] = bin[i+1] ^ g[i];
        return bin;
    endfunction

    task automatic stamp_word(input logic [4:0] sid, input logic [31:0] a,
                              input logic [15:0] b, output result_t res);
        logic            ext;
        logic            is_hit;
        logic [4:0]      chip;
        logic [TS_W-1:0] ts42;
        logic [TS_W-1:0] t;
        logic [HM_W-1:0] hm20;
        int              idx;
        int              tidx;
        res = '0;
        ext = (trig_mode == TRIG_MODE_EXTERNAL);
        is_hit = b[15];
        chip = is_hit ? a[26:22] : b[14:10];
        res.chip = chip;
        if (int'(sid) < int'(SID_FIRST) || int'(sid) > int'(SID_BASE + NUM_FECS)) begin
            res.kind = KIND_PASS;
        end
        else begin
            idx = (int'(sid) - int'(SID_FIRST)) * NUM_CHIPS + int'(chip);
            if (is_hit) begin
                res.kind = KIND_HIT;
                res.chan = b[13:8];
                if (ext) begin
                    tidx = idx + int'(TRIG_ENTRY_OFFSET);
                    t = (tidx < TABLE_DEPTH) ? marker_time[tidx] : '0;
                    if (t == '0)
                        early_hits++;
                    res.ts = OUT_TS_W'(t);
                    res.hm = marker_hm[idx];
                end
                else if (marker_time[idx] == '0) begin
                    early_hits++;
                end
                else begin
                    res.ts = OUT_TS_W'(marker_time[idx]) + {26'd0, a[31:27], 12'd0}
                             + OUT_TS_W'(bunch_from_gray(a[11:0]));
                end
            end
            else begin
                ts42 = {a, b[9:0]};
                hm20 = {a[9:0], b[9:0]};
                if (ext && ts42 == '1) begin
                    if (!run_over)
                        for (int i = 0; i < TABLE_DEPTH; i++)
                            marker_hm[i] = '0;
                    run_over = 1'b1;
                    res.kind = KIND_PASS;
                end
                else if (!entry_started[idx]) begin
                    marker_time[idx] = '0;
                    entry_started[idx] = 1'b1;
                    run_over = 1'b1;
                    res.kind = KIND_PASS;
                end
                else if (ext) begin
                    if (hm20 != '0 && chip <= CHIP_SPLIT) begin
                        marker_hm[idx] = hm20;
                    end
                    else if (ts42 != '0 && chip > CHIP_SPLIT) begin
                        marker_time[idx] = ts42;
                        res.ts = OUT_TS_W'(ts42);
                        res.kind = KIND_TRIG;
                    end
                    else if (chip > CHIP_SPLIT) begin
                        bad_markers++;
                        res.kind = KIND_ERR;
                    end
                end
                else if (chip < CHIP_SPLIT) begin
                    if (ts42 != '0) begin
                        marker_time[idx] = ts42;
                        res.ts = OUT_TS_W'(ts42);
                    end
                    else begin
                        bad_markers++;
                        res.kind = KIND_ERR;
                    end
                end
            end
        end
        res.early = early_hits;
        res.err = bad_markers;
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        result_t got;
        if (!rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                marker_time[i] = '0;
                marker_hm[i] = '0;
                entry_started[i] = 1'b0;
            end
            run_over = 1'b0;
            early_hits = '0;
            bad_markers = '0;
            trig_mode = '0;
            expected_stamps.delete();
            queued = 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == TRIGGER_MODE_ADDR)
                trig_mode = pwdata[1:0];
            if (done) begin
                got = {kind, timestamp, hit_marker, chip_id, channel,
                       early_data_count, marker_error_count};
                if (expected_stamps.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("checker: result beat with nothing expected, kind=%0d ts=%h",
                                 got.kind, got.ts);
                end
                else begin
                    want = expected_stamps.pop_front();
                    compared++;
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("checker: mismatch on result %0d", compared);
                            $display("  want kind=%0d ts=%h hm=%h chip=%0d chan=%0d early=%0d err=%0d",
                                     want.kind, want.ts, want.hm, want.chip, want.chan,
                                     want.early, want.err);
                            $display("  got  kind=%0d ts=%h hm=%h chip=%0d chan=%0d early=%0d err=%0d",
                                     got.kind, got.ts, got.hm, got.chip, got.chan,
                                     got.early, got.err);
                        end
                    end
                end
            end
            if (start && !busy) begin
                stamp_word(source_id, data_word_a, data_word_b, want);
                expected_stamps.push_back(want);
            end
            queued = expected_stamps.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import vhmt_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_WORDS = 225;
    localparam logic [CFG_ADDR_W-1:0] TRIGGER_MODE_ADDR = {REG_TRIGGER_MODE, 2'b00};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  start = 1'b0;
    logic                  busy;
    logic [4:0]            source_id = '0;
    logic [31:0]           data_word_a = '0;
    logic [15:0]           data_word_b = '0;
    logic                  done;
    logic [2:0]            kind;
    logic [OUT_TS_W-1:0]   timestamp;
    logic [HM_W-1:0]       hit_marker;
    logic [4:0]            chip_id;
    logic [5:0]            channel;
    logic [31:0]           early_data_count;
    logic [31:0]           marker_error_count;

    int fail_count;
    int pending;
    int checked;
    int words_sent = 0;
    int quiet_cycles = 0;

    always #4 clk = ~clk;

    vmm_hit_marker_timestamper_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .start              (start),
        .busy               (busy),
        .source_id          (source_id),
        .data_word_a        (data_word_a),
        .data_word_b        (data_word_b),
        .done               (done),
        .kind               (kind),
        .timestamp          (timestamp),
        .hit_marker         (hit_marker),
        .chip_id            (chip_id),
        .channel            (channel),
        .early_data_count   (early_data_count),
        .marker_error_count (marker_error_count)
    );

    timestamp_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .start              (start),
        .busy               (busy),
        .source_id          (source_id),
        .data_word_a        (data_word_a),
        .data_word_b        (data_word_b),
        .done               (done),
        .kind               (kind),
        .timestamp          (timestamp),
        .hit_marker         (hit_marker),
        .chip_id            (chip_id),
        .channel            (channel),
        .early_data_count   (early_data_count),
        .marker_error_count (marker_error_count),
        .fail_count         (fail_count),
        .pending            (pending),
        .checked            (checked)
    );

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("testbench: done, errors");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [4:0] sid, input logic [31:0] a, input logic [15:0] b);
        logic held;
        start <= 1'b1;
        source_id <= sid;
        data_word_a <= a;
        data_word_b <= b;
        do begin
            @(negedge clk);
            held = busy;
            @(posedge clk);
        end while (held);
        words_sent++;
    endtask

    task automatic send_marker(input logic [4:0] sid, input logic [4:0] chip,
                               input logic [TS_W-1:0] ts);
        send_word(sid, ts[41:10], {1'b0, chip, ts[9:0]});
    endtask

    task automatic send_hit(input logic [4:0] sid, input logic [4:0] chip, input logic [4:0] toff,
                            input logic [11:0] gray, input logic [5:0] chan);
        send_word(sid, {toff, chip, 10'($urandom), gray},
                  {1'b1, 1'($urandom), chan, 8'($urandom)});
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_trigger_mode(input logic [1:0] mode);
        logic ready;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TRIGGER_MODE_ADDR;
        pwdata <= 32'(mode);
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(negedge clk);
            ready = pready;
            @(posedge clk);
        end while (!ready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_random_word();
        logic [4:0]      sid;
        logic [4:0]      chip;
        logic [TS_W-1:0] ts;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 8)
            sid = 5'($urandom_range(0, 31));
        else if (r < 70)
            sid = 5'($urandom_range(11, 12));
        else
            sid = 5'($urandom_range(11, 26));
        chip = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 1) == 1) begin
            send_hit(sid, chip, 5'($urandom), 12'($urandom), 6'($urandom));
        end
        else begin
            r = $urandom_range(0, 99);
            if (r < 6)
                ts = '0;
            else if (r < 12)
                ts = {22'($urandom), 20'd0};
            else if (r < 14)
                ts = '1;
            else
                ts = {$urandom, 10'($urandom)};
            send_marker(sid, chip, ts);
        end
    endtask

    task automatic run_phase(input logic [1:0] mode, input int count, input bit with_gaps);
        drain_results();
        write_trigger_mode(mode);
        for (int i = 0; i < count; i++) begin
            if (with_gaps && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 4));
            send_random_word();
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // external trigger: end marker before any entry starts, then the trigger path
        write_trigger_mode(TRIG_MODE_EXTERNAL);
        send_marker(5'd11, 5'd31, '1);
        send_hit(5'd11, 5'd0, 5'd0, 12'h000, 6'd0);
        send_marker(5'd11, 5'd16, 42'h1);
        send_marker(5'd11, 5'd16, 42'h2AA_AAAA_AAAA);
        send_marker(5'd11, 5'd16, '0);
        send_marker(5'd11, 5'd0, 42'h5);
        send_marker(5'd11, 5'd0, 42'hF_FFFF);
        send_marker(5'd11, 5'd0, 42'h3FF_FFF0_0000);
        send_hit(5'd11, 5'd0, 5'd31, 12'hFFF, 6'd63);
        send_hit(5'd26, 5'd31, 5'd0, 12'h000, 6'd0);
        send_marker(5'd11, 5'd31, '1);
        send_hit(5'd11, 5'd0, 5'd1, 12'h001, 6'd1);
        send_hit(5'd0, 5'd31, 5'd31, 12'hFFF, 6'd63);
        send_marker(5'd31, 5'd31, '1);
        send_marker(5'd10, 5'd0, 42'h1);
        send_hit(5'd27, 5'd5, 5'd3, 12'h123, 6'd9);

        // internal trigger: all-ones is an ordinary marker, chip boundary at fifteen
        drain_results();
        write_trigger_mode(2'd0);
        send_hit(5'd12, 5'd3, 5'd1, 12'h800, 6'd5);
        send_marker(5'd12, 5'd3, '1);
        send_marker(5'd12, 5'd3, '1);
        send_hit(5'd12, 5'd3, 5'd31, 12'hFFF, 6'd63);
        send_marker(5'd12, 5'd14, 42'h7);
        send_marker(5'd12, 5'd14, '0);
        send_marker(5'd12, 5'd15, 42'h8);
        send_marker(5'd12, 5'd15, 42'h9);
        send_hit(5'd12, 5'd15, 5'd2, 12'h0F0, 6'd32);

        run_phase(2'd2, PHASE_WORDS, 1'b1);
        run_phase(TRIG_MODE_EXTERNAL, PHASE_WORDS, 1'b1);
        run_phase(2'd3, PHASE_WORDS, 1'b1);
        run_phase(2'd0, PHASE_WORDS, 1'b1);
        // hold start high throughout the closing stretch
        run_phase(TRIG_MODE_EXTERNAL, PHASE_WORDS, 1'b0);

        drain_results();
        repeat (10) @(posedge clk);
        $display("testbench: %0d readout words sent, %0d results checked, %0d failures",
                 words_sent, checked, fail_count);
        $display("testbench: trigger modes 0 to 3, hits, markers, end markers, bad sources");
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
